// File: design/ste_pkg.sv
package ste_pkg;

    localparam int MAX_ROWS_DEF    = 16;
    localparam int MAX_COLS_DEF    = 32;
    localparam int MAX_ENTRIES_DEF = 256;

    localparam int ROW_W = 4;
    localparam int COL_W = 5;
    localparam int VAL_W = 9;
    localparam int CNT_W = 9;
    localparam int CFG_W = 5;

    localparam logic [CFG_W-1:0] ROW_COUNT_RESET = CFG_W'(16);

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_EVAC  = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_WR_RD,
        S_WR_WB,
        S_POS_RD,
        S_POS_LD,
        S_RD_W,
        S_RD_N,
        S_STEP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [ROW_W-1:0] top_row;
        logic [COL_W-1:0] top_col;
        logic [ROW_W-1:0] reflected_row;
        logic [CNT_W-1:0] entries_left;
        logic             report_valid;
    } t_result;

endpackage

// File: design/ste_if.sv
interface ste_req_if;
    logic                        valid;
    logic                        ready;
    logic                        mode;
    logic [ste_pkg::ROW_W-1:0]   cell_row;
    logic [ste_pkg::COL_W-1:0]   cell_col;
    logic [ste_pkg::VAL_W-1:0]   entry_value;

    modport source (output valid, mode, cell_row, cell_col, entry_value, input ready);
    modport sink   (input valid, mode, cell_row, cell_col, entry_value, output ready);
endinterface

interface ste_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [ste_pkg::ROW_W-1:0]   top_row;
    logic [ste_pkg::COL_W-1:0]   top_col;
    logic [ste_pkg::ROW_W-1:0]   reflected_row;
    logic [ste_pkg::CNT_W-1:0]   entries_left;
    logic                        report_valid;

    modport source (output valid, top_row, top_col, reflected_row, entries_left,
                    report_valid, input ready);
    modport sink   (input valid, top_row, top_col, reflected_row, entries_left,
                    report_valid, output ready);
endinterface

// File: design/ste_ram.sv
module ste_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/ste_seq.sv
module ste_seq #(
    parameter int MAX_ROWS    = ste_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS    = ste_pkg::MAX_COLS_DEF,
    parameter int MAX_ENTRIES = ste_pkg::MAX_ENTRIES_DEF,
    localparam int RW         = $clog2(MAX_ROWS),
    localparam int CW         = $clog2(MAX_COLS),
    localparam int AW         = RW + CW,
    localparam int VW         = $clog2(MAX_ENTRIES + 1),
    localparam int PAW        = $clog2(MAX_ENTRIES)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic                      i_mode,
    input  logic [ste_pkg::ROW_W-1:0] i_cell_row,
    input  logic [ste_pkg::COL_W-1:0] i_cell_col,
    input  logic [ste_pkg::VAL_W-1:0] i_entry_value,
    input  logic [ste_pkg::CFG_W-1:0] i_row_count,
    output logic                      o_cell_we,
    output logic [AW-1:0]             o_cell_waddr,
    output logic [VW-1:0]             o_cell_wdata,
    output logic [AW-1:0]             o_cell_raddr,
    input  logic [VW-1:0]             i_cell_rdata,
    output logic                      o_pos_we,
    output logic [PAW-1:0]            o_pos_waddr,
    output logic [AW-1:0]             o_pos_wdata,
    output logic [PAW-1:0]            o_pos_raddr,
    input  logic [AW-1:0]             i_pos_rdata,
    output logic                      o_res_valid,
    input  logic                      i_res_ready,
    output ste_pkg::t_result          o_res
);

    import ste_pkg::*;

    t_state r_state;
    t_state n_state;

    logic [AW-1:0]    r_clr;
    logic [VW-1:0]    r_count;
    logic [RW-1:0]    r_row;
    logic [CW-1:0]    r_col;
    logic [VW-1:0]    r_val;
    logic [VW-1:0]    r_wv;
    logic [ROW_W-1:0] r_top_row;
    logic [COL_W-1:0] r_top_col;
    logic [ROW_W-1:0] r_refl;
    logic             r_rep;

    logic             wr_ok;
    logic [VW-1:0]    nv;
    logic             stop;
    logic             take_w;
    logic [VW-1:0]    step_val;
    logic [RW-1:0]    step_row;
    logic [CW-1:0]    step_col;
    logic [ROW_W-1:0] pos_row4;

    assign wr_ok = (i_entry_value != '0)
                && (32'(i_entry_value) <= MAX_ENTRIES)
                && (32'(i_cell_row) < MAX_ROWS)
                && (32'(i_cell_col) < MAX_COLS);

    always_comb begin
        nv       = (r_row != '0) ? i_cell_rdata : '0;
        stop     = (r_wv == '0) && (nv == '0);
        take_w   = (r_wv != '0) && ((nv == '0) || (r_wv >= nv));
        step_val = take_w ? r_wv : nv;
        step_row = take_w ? r_row : r_row - RW'(1);
        step_col = take_w ? r_col - CW'(1) : r_col;
    end

    assign pos_row4 = ROW_W'(i_pos_rdata[AW-1:CW]);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr == AW'((MAX_ROWS << CW) - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_mode == MODE_WRITE) begin
                        n_state = wr_ok ? S_WR_RD : S_DONE;
                    end else begin
                        n_state = (r_count == '0) ? S_DONE : S_POS_RD;
                    end
                end
            end
            S_WR_RD:  n_state = S_WR_WB;
            S_WR_WB:  n_state = S_DONE;
            S_POS_RD: n_state = S_POS_LD;
            S_POS_LD: n_state = S_RD_W;
            S_RD_W:   n_state = S_RD_N;
            S_RD_N:   n_state = S_STEP;
            S_STEP: begin
                n_state = stop ? S_DONE : S_RD_N;
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        o_in_ready   = 1'b0;
        o_res_valid  = 1'b0;
        o_cell_we    = 1'b0;
        o_cell_waddr = {r_row, r_col};
        o_cell_wdata = '0;
        o_cell_raddr = {r_row, r_col};
        o_pos_we     = 1'b0;
        o_pos_waddr  = PAW'(r_val - VW'(1));
        o_pos_wdata  = {r_row, r_col};
        o_pos_raddr  = PAW'(r_count - VW'(1));
        case (r_state)
            S_CLEAR: begin
                o_cell_we    = 1'b1;
                o_cell_waddr = r_clr;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
            end
            S_WR_WB: begin
                o_cell_we    = 1'b1;
                o_cell_wdata = r_val;
                o_pos_we     = 1'b1;
            end
            S_RD_W: begin
                o_cell_raddr = {r_row, r_col - CW'(1)};
            end
            S_RD_N: begin
                o_cell_raddr = {r_row - RW'(1), r_col};
            end
            S_STEP: begin
                o_cell_we    = 1'b1;
                o_cell_wdata = stop ? '0 : step_val;
                o_pos_we     = !stop;
                o_pos_waddr  = PAW'(step_val - VW'(1));
                o_cell_raddr = {step_row, step_col - CW'(1)};
            end
            S_DONE: begin
                o_res_valid = 1'b1;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end
            if (r_state == S_WR_WB && i_cell_rdata == '0
                    && r_count < VW'(MAX_ENTRIES)) begin
                r_count <= r_count + VW'(1);
            end
            if (r_state == S_STEP && stop) begin
                r_count <= r_count - VW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    r_row     <= RW'(i_cell_row);
                    r_col     <= CW'(i_cell_col);
                    r_val     <= VW'(i_entry_value);
                    r_top_row <= '0;
                    r_top_col <= '0;
                    r_refl    <= '0;
                    r_rep     <= 1'b0;
                end
            end
            S_POS_LD: begin
                r_row     <= i_pos_rdata[AW-1:CW];
                r_col     <= i_pos_rdata[CW-1:0];
                r_top_row <= pos_row4;
                r_top_col <= COL_W'(i_pos_rdata[CW-1:0]);
                r_refl    <= ROW_W'(i_row_count) - ROW_W'(1) - pos_row4;
                r_rep     <= 1'b1;
            end
            S_RD_N: begin
                r_wv <= (r_col != '0) ? i_cell_rdata : '0;
            end
            S_STEP: begin
                if (!stop) begin
                    r_row <= step_row;
                    r_col <= step_col;
                end
            end
            default: begin
                r_rep <= r_rep;
            end
        endcase
    end

    assign o_res.top_row       = r_top_row;
    assign o_res.top_col       = r_top_col;
    assign o_res.reflected_row = r_refl;
    assign o_res.entries_left  = CNT_W'(r_count);
    assign o_res.report_valid  = r_rep;

endmodule

// File: design/shifted_tableau_evacuation.sv
// Shifted tableau store with evacuation by sliding.
// Requests arrive on i_req. A request in write mode places entry_value at
// (cell_row, cell_col); one in evacuate mode reports where the largest entry
// sits, with its row reflected against row_count, and then slides entries
// into the freed cell until the path ends. Every request gives one response
// on o_rsp, which carries the entry count after the request.
// A write request reads the cell and then writes it back before it responds;
// an ignored write or an evacuation of an empty tableau responds with no RAM access.
// Each slide step of an evacuation reads the west and north neighbors through
// the single read port of the cell RAM; the slide path has at most
// MAX_ROWS + MAX_COLS - 2 steps.
// One request is worked on at a time; the next one is accepted while the
// previous response still waits in the output register.
// After reset the cell RAM is swept to zero, one entry per cycle, over
// MAX_ROWS * 2**ceil(log2(MAX_COLS)) entries (512 by default); no request is
// accepted during the sweep, while row_count writes are taken at any time.
// When the receiver stalls, the response holds and a finished request waits
// until the output register frees up.
module shifted_tableau_evacuation #(
    parameter int MAX_ROWS    = ste_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS    = ste_pkg::MAX_COLS_DEF,
    parameter int MAX_ENTRIES = ste_pkg::MAX_ENTRIES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [ste_pkg::CFG_W-1:0] i_cfg_wdata,
    ste_req_if.sink                   i_req,
    ste_rsp_if.source                 o_rsp
);

    import ste_pkg::*;

    localparam int RW  = $clog2(MAX_ROWS);
    localparam int CW  = $clog2(MAX_COLS);
    localparam int AW  = RW + CW;
    localparam int VW  = $clog2(MAX_ENTRIES + 1);
    localparam int PAW = $clog2(MAX_ENTRIES);

    logic [CFG_W-1:0] r_row_count;
    logic             r_out_valid;
    t_result          r_out;

    logic             cell_we;
    logic [AW-1:0]    cell_waddr;
    logic [VW-1:0]    cell_wdata;
    logic [AW-1:0]    cell_raddr;
    logic [VW-1:0]    cell_rdata;
    logic             pos_we;
    logic [PAW-1:0]   pos_waddr;
    logic [AW-1:0]    pos_wdata;
    logic [PAW-1:0]   pos_raddr;
    logic [AW-1:0]    pos_rdata;
    logic             res_valid;
    logic             res_ready;
    t_result          res;

    assign res_ready = !r_out_valid || o_rsp.ready;

    ste_ram #(
        .WIDTH (VW),
        .DEPTH (MAX_ROWS << CW)
    ) u_cell_ram (
        .i_clk   (i_clk),
        .i_we    (cell_we),
        .i_waddr (cell_waddr),
        .i_wdata (cell_wdata),
        .i_raddr (cell_raddr),
        .o_rdata (cell_rdata)
    );

    ste_ram #(
        .WIDTH (AW),
        .DEPTH (MAX_ENTRIES)
    ) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (pos_we),
        .i_waddr (pos_waddr),
        .i_wdata (pos_wdata),
        .i_raddr (pos_raddr),
        .o_rdata (pos_rdata)
    );

    ste_seq #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLS    (MAX_COLS),
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_req.valid),
        .o_in_ready    (i_req.ready),
        .i_mode        (i_req.mode),
        .i_cell_row    (i_req.cell_row),
        .i_cell_col    (i_req.cell_col),
        .i_entry_value (i_req.entry_value),
        .i_row_count   (r_row_count),
        .o_cell_we     (cell_we),
        .o_cell_waddr  (cell_waddr),
        .o_cell_wdata  (cell_wdata),
        .o_cell_raddr  (cell_raddr),
        .i_cell_rdata  (cell_rdata),
        .o_pos_we      (pos_we),
        .o_pos_waddr   (pos_waddr),
        .o_pos_wdata   (pos_wdata),
        .o_pos_raddr   (pos_raddr),
        .i_pos_rdata   (pos_rdata),
        .o_res_valid   (res_valid),
        .i_res_ready   (res_ready),
        .o_res         (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= ROW_COUNT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_row_count <= i_cfg_wdata;
            end
            if (res_valid && res_ready) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.top_row       = r_out.top_row;
    assign o_rsp.top_col       = r_out.top_col;
    assign o_rsp.reflected_row = r_out.reflected_row;
    assign o_rsp.entries_left  = r_out.entries_left;
    assign o_rsp.report_valid  = r_out.report_valid;

endmodule

// File: bench/tb_shifted_tableau_evacuation.sv
module tb_shifted_tableau_evacuation;
    import ste_pkg::*;

    localparam int RANDOM_ITEMS  = 1200;
    localparam int FILL_WRITES   = 280;
    localparam int FILL_EVACS    = 40;
    localparam int IDLE_LIMIT    = 4000;
    localparam int LONG_HOLD     = 300;
    localparam int SETTLE_CYCLES = 200;

    typedef struct {
        int row;
        int col;
        int val;
    } t_cell_write;

    class tableau_shadow;
        bit [VAL_W-1:0] cells [MAX_ROWS_DEF][MAX_COLS_DEF];
        bit [ROW_W-1:0] pos_row [MAX_ENTRIES_DEF];
        bit [COL_W-1:0] pos_col [MAX_ENTRIES_DEF];
        bit             pos_known [MAX_ENTRIES_DEF];
        int unsigned    n_entries;
        bit [CFG_W-1:0] row_count;
        t_result        pending_reports [$];
        int unsigned    mismatches;

        function new();
            row_count  = ROW_COUNT_RESET;
            n_entries  = 0;
            mismatches = 0;
        endfunction

        // The position of the largest value must have been written at some point.
        function bit evac_safe();
            return n_entries == 0 || pos_known[n_entries-1];
        endfunction

        function void place(int v, int r, int c);
            cells[r][c]    = VAL_W'(v);
            pos_row[v-1]   = ROW_W'(r);
            pos_col[v-1]   = COL_W'(c);
            pos_known[v-1] = 1'b1;
        endfunction

        function void note_request(logic mode, int r_in, int c_in, int v_in);
            t_result rep;
            int      r;
            int      c;
            int      wv;
            int      nv;
            rep = '0;
            if (mode == MODE_WRITE) begin
                if (v_in != 0 && v_in <= MAX_ENTRIES_DEF) begin
                    if (cells[r_in][c_in] == 0 && n_entries < MAX_ENTRIES_DEF)
                        n_entries++;
                    place(v_in, r_in, c_in);
                end
            end else if (n_entries != 0) begin
                r = pos_row[n_entries-1];
                c = pos_col[n_entries-1];
                rep.top_row       = ROW_W'(r);
                rep.top_col       = COL_W'(c);
                rep.reflected_row = ROW_W'(int'(row_count) - 1 - r);
                rep.report_valid  = 1'b1;
                while (1) begin
                    wv = (c > 0) ? int'(cells[r][c-1]) : 0;
                    nv = (r > 0) ? int'(cells[r-1][c]) : 0;
                    if (wv == 0 && nv == 0)
                        break;
                    if (wv != 0 && (nv == 0 || wv >= nv)) begin
                        place(wv, r, c);
                        c--;
                    end else begin
                        place(nv, r, c);
                        r--;
                    end
                end
                cells[r][c] = '0;
                n_entries--;
            end
            rep.entries_left = CNT_W'(n_entries);
            pending_reports.insert(pending_reports.size(), rep);
        endfunction

        function void check_field(string what, int want, int got);
            if (want != got) begin
                mismatches++;
                $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
            end
        endfunction

        function void check_response(t_result got);
            t_result want;
            if (pending_reports.size() == 0) begin
                mismatches++;
                $display("%0t: response expected none, got entries_left %0d", $time,
                         got.entries_left);
                return;
            end
            want = pending_reports.pop_front();
            check_field("top_row", want.top_row, got.top_row);
            check_field("top_col", want.top_col, got.top_col);
            check_field("reflected_row", want.reflected_row, got.reflected_row);
            check_field("entries_left", want.entries_left, got.entries_left);
            check_field("report_valid", want.report_valid, got.report_valid);
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;

    ste_req_if req_if();
    ste_rsp_if rsp_if();

    tableau_shadow shadow;
    int unsigned   items_sent;
    bit            sender_burst;

    t_cell_write seed_tableau [8] = '{
        '{0, 0, 1}, '{0, 0, 1}, '{0, 1, 2}, '{0, 2, 3},
        '{1, 1, 4}, '{0, 3, 5}, '{1, 2, 6}, '{2, 2, 7}
    };

    shifted_tableau_evacuation u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata),
        .i_req      (req_if),
        .o_rsp      (rsp_if)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic issue_request(logic mode, int row, int col, int val, bit counted);
        int gap;
        gap = sender_burst ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid       <= 1'b1;
        req_if.mode        <= mode;
        req_if.cell_row    <= ROW_W'(row);
        req_if.cell_col    <= COL_W'(col);
        req_if.entry_value <= VAL_W'(val);
        do @(posedge clk); while (!req_if.ready);
        shadow.note_request(mode, row, col, val);
        if (counted)
            items_sent++;
    endtask

    task automatic evacuate();
        if (shadow.evac_safe())
            issue_request(MODE_EVAC, $urandom_range(0, 15), $urandom_range(0, 31),
                          $urandom_range(0, 511), 1'b1);
    endtask

    // A write request with a value out of range leaves the tableau untouched.
    task automatic send_noise();
        issue_request(MODE_WRITE, $urandom_range(0, 15), $urandom_range(0, 31),
                      $urandom_range(0, 1) ? 0 : $urandom_range(257, 511), 1'b0);
    endtask

    task automatic wait_drained();
        req_if.valid <= 1'b0;
        do @(posedge clk); while (shadow.pending_reports.size() != 0);
    endtask

    task automatic write_row_count(logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        shadow.row_count = value;
        cfg_we <= 1'b0;
    endtask

    // Loads a random shifted standard tableau in random order, then evacuates it.
    task automatic run_tableau();
        int          lam [MAX_ROWS_DEF];
        int          grown [MAX_ROWS_DEF];
        int          nrows;
        int          total;
        int          pick;
        int          open_rows [$];
        t_cell_write plan [$];
        t_cell_write tmp;
        lam[0] = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 22) : $urandom_range(1, 6);
        total  = lam[0];
        nrows  = 1;
        while (nrows < MAX_ROWS_DEF && lam[nrows-1] > 1 && $urandom_range(0, 2) != 0) begin
            lam[nrows] = $urandom_range(1, lam[nrows-1] - 1);
            total += lam[nrows];
            nrows++;
        end
        foreach (grown[i])
            grown[i] = 0;
        for (int v = 1; v <= total; v++) begin
            open_rows.delete();
            for (int i = 0; i < nrows; i++) begin
                if (grown[i] < lam[i] && (i == 0 || grown[i-1] > grown[i] + 1))
                    open_rows.insert(open_rows.size(), i);
            end
            pick = open_rows[$urandom_range(0, open_rows.size() - 1)];
            tmp  = '{pick, pick + grown[pick], v};
            plan.insert(plan.size(), tmp);
            grown[pick]++;
        end
        for (int k = plan.size() - 1; k > 0; k--) begin
            pick       = $urandom_range(0, k);
            tmp        = plan[k];
            plan[k]    = plan[pick];
            plan[pick] = tmp;
        end
        foreach (plan[i]) begin
            if ($urandom_range(0, 9) == 0)
                send_noise();
            issue_request(MODE_WRITE, plan[i].row, plan[i].col, plan[i].val, 1'b1);
            if ($urandom_range(0, 7) == 0)
                issue_request(MODE_WRITE, plan[i].row, plan[i].col, plan[i].val, 1'b1);
        end
        while (shadow.n_entries != 0 && shadow.evac_safe()) begin
            if ($urandom_range(0, 9) == 0)
                send_noise();
            evacuate();
        end
        if ($urandom_range(0, 1) == 0)
            evacuate();
    endtask

    initial begin
        shadow = new();
        items_sent   = 0;
        sender_burst = 1'b0;
        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_wdata          <= '0;
        req_if.valid       <= 1'b0;
        req_if.mode        <= MODE_WRITE;
        req_if.cell_row    <= '0;
        req_if.cell_col    <= '0;
        req_if.entry_value <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        write_row_count(CFG_W'(1));

        evacuate();
        issue_request(MODE_WRITE, 15, 31, 0, 1'b1);
        issue_request(MODE_WRITE, 10, 21, 257, 1'b1);
        issue_request(MODE_WRITE, 5, 10, 511, 1'b1);
        foreach (seed_tableau[i])
            issue_request(MODE_WRITE, seed_tableau[i].row, seed_tableau[i].col,
                          seed_tableau[i].val, 1'b1);
        repeat (8) evacuate();
        wait_drained();
        write_row_count(CFG_W'(16));

        while (items_sent < RANDOM_ITEMS - FILL_WRITES - FILL_EVACS) begin
            if ($urandom_range(0, 7) == 0) begin
                wait_drained();
                case ($urandom_range(0, 3))
                    0: begin
                        write_row_count(CFG_W'(1));
                    end
                    1: begin
                        write_row_count(CFG_W'(16));
                    end
                    default: begin
                        write_row_count(CFG_W'($urandom_range(1, 16)));
                    end
                endcase
            end
            sender_burst = ($urandom_range(0, 3) == 0);
            run_tableau();
        end

        // Fill distinct cells past the entry limit, then evacuate the inconsistent contents.
        wait_drained();
        write_row_count(CFG_W'($urandom_range(1, 16)));
        sender_burst = 1'b0;
        for (int k = 0; k < FILL_WRITES; k++)
            issue_request(MODE_WRITE, ((k * 97) % 512) / 32, (k * 97) % 32,
                          (k % MAX_ENTRIES_DEF) + 1, 1'b1);
        repeat (FILL_EVACS) evacuate();

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (shadow.mismatches == 0 && shadow.pending_reports.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        int      gap;
        int      seen;
        bit      burst;
        t_result got;
        rsp_if.ready <= 1'b0;
        seen  = 0;
        burst = 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            if (seen % 64 == 0)
                burst = ($urandom_range(0, 2) == 0);
            if (seen == 150 || seen == 700)
                gap = LONG_HOLD;
            else
                gap = burst ? 0 : $urandom_range(0, 8);
            if (gap > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_if.ready <= 1'b1;
            do @(posedge clk); while (!rsp_if.valid);
            got.top_row       = rsp_if.top_row;
            got.top_col       = rsp_if.top_col;
            got.reflected_row = rsp_if.reflected_row;
            got.entries_left  = rsp_if.entries_left;
            got.report_valid  = rsp_if.report_valid;
            shadow.check_response(got);
            seen++;
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge clk);
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAILED: results differ");
        $finish;
    end

endmodule
